[sv/msedt_pkg.sv]
// ----------------------------------------------------------------------------
// msedt_pkg
// Shared types and constants for the MIPS subset executor with DRAM timing.
// ----------------------------------------------------------------------------
package msedt_pkg;

  // default sizes
  localparam int unsigned DEF_MEM_WORDS = 262144;
  localparam int unsigned DEF_ROW_BYTES = 1024;

  // field widths
  localparam int unsigned FUNC_W = 4;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STS_W  = 3;
  localparam int unsigned LINE_W = 16;
  localparam int unsigned DBW_W  = 18;
  localparam int unsigned DLY_W  = 8;
  localparam int unsigned CNT_W  = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // function codes
  localparam logic [FUNC_W-1:0] FN_ADD  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_SUB  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MUL  = 4'd2;
  localparam logic [FUNC_W-1:0] FN_BEQ  = 4'd3;
  localparam logic [FUNC_W-1:0] FN_BNE  = 4'd4;
  localparam logic [FUNC_W-1:0] FN_SLT  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_J    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_LW   = 4'd7;
  localparam logic [FUNC_W-1:0] FN_SW   = 4'd8;
  localparam logic [FUNC_W-1:0] FN_ADDI = 4'd9;

  // status codes
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_EMPTY_REG = 3'd1;
  localparam logic [STS_W-1:0] STS_MISALIGN  = 3'd2;
  localparam logic [STS_W-1:0] STS_OOM       = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY_MEM = 3'd4;
  localparam logic [STS_W-1:0] STS_BAD_TGT   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LINES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_DELAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_DELAY = 2'd3;

  // reset values
  localparam logic [LINE_W-1:0] RST_PROG_LINES = 16'd1;
  localparam logic [DLY_W-1:0]  RST_ROW_DELAY  = 8'd10;
  localparam logic [DLY_W-1:0]  RST_COL_DELAY  = 8'd2;
  localparam logic [REG_W-1:0]  SP_REG         = 5'd29;
  localparam logic [DATA_W-1:0] SP_INIT        = 32'd1048576;
  localparam logic [31:0]       RST_REG_VALID  = 32'h2000_0001;

  // controller states
  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_READ,
    CS_ADDR,
    CS_EXEC
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr;
    logic accept;
    logic read;
    logic addr;
    logic exec;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
  } dp_sts_t;

endpackage

[sv/msedt_ctl.sv]
// ----------------------------------------------------------------------------
// msedt_ctl
// Sequencer: memory clear after reset, item stages, and both handshakes.
// ----------------------------------------------------------------------------
module msedt_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  msedt_pkg::dp_sts_t dp_sts,
  output msedt_pkg::dp_cmd_t dp_cmd
);
  import msedt_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    in_ready  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      CS_CLEAR: begin
        dp_cmd.clr = 1'b1;
        if (dp_sts.clr_last) state_nxt = CS_IDLE;
      end
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.accept = 1'b1;
          state_nxt     = CS_READ;
        end
      end
      CS_READ: begin
        dp_cmd.read = 1'b1;
        state_nxt   = CS_ADDR;
      end
      CS_ADDR: begin
        dp_cmd.addr = 1'b1;
        state_nxt   = CS_EXEC;
      end
      CS_EXEC: begin
        if (slot_free) begin
          dp_cmd.exec   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = CS_IDLE;
        end
      end
      default: state_nxt = CS_CLEAR;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // an accepted beat always moves on to the register read
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == CS_READ))
    else $error("accepted beat did not enter read stage");
  // no beat is taken while the memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_CLEAR) |-> !in_ready)
    else $error("input ready during memory clear");
  // a result is presented after every execute step
  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.exec |=> out_valid_r)
    else $error("execute without result");
  // a pending result is never dropped
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("result dropped without handshake");
`endif

endmodule

[sv/msedt_dp.sv]
// ----------------------------------------------------------------------------
// msedt_dp
// Datapath: register file, data memory, config registers, checks, counters.
// ----------------------------------------------------------------------------
module msedt_dp #(
  parameter int unsigned MEM_WORDS = msedt_pkg::DEF_MEM_WORDS,
  parameter int unsigned ROW_BYTES = msedt_pkg::DEF_ROW_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  msedt_pkg::dp_cmd_t                   dp_cmd,
  output msedt_pkg::dp_sts_t                   dp_sts,
  input  logic                                 cfg_wr,
  input  logic [msedt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msedt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [msedt_pkg::FUNC_W-1:0]         in_func,
  input  logic [msedt_pkg::REG_W-1:0]          in_dest_reg,
  input  logic [msedt_pkg::REG_W-1:0]          in_src_a,
  input  logic [msedt_pkg::REG_W-1:0]          in_src_b,
  input  logic                                 in_use_a,
  input  logic                                 in_use_b,
  input  logic signed [msedt_pkg::DATA_W-1:0]  in_imm,
  output logic [msedt_pkg::STS_W-1:0]          out_status,
  output logic                                 out_taken,
  output logic [msedt_pkg::LINE_W-1:0]         out_next_line,
  output logic                                 out_dram_issued,
  output logic [msedt_pkg::DATA_W-1:0]         out_issue_cycle,
  output logic [msedt_pkg::DATA_W-1:0]         out_cycle_total,
  output logic                                 out_reg_written,
  output logic [msedt_pkg::REG_W-1:0]          out_written_index,
  output logic signed [msedt_pkg::DATA_W-1:0]  out_written_value,
  output logic                                 out_new_word,
  output logic [msedt_pkg::CNT_W-1:0]          out_words_stored
);
  import msedt_pkg::*;

  localparam int unsigned AW     = $clog2(MEM_WORDS);
  localparam int unsigned ROW_SH = $clog2(ROW_BYTES);
  localparam int unsigned ROW_W  = $clog2((MEM_WORDS * 4 - 1) / ROW_BYTES + 2);
  localparam logic [AW-1:0]     CLR_LAST = AW'(MEM_WORDS - 1);
  localparam logic signed [31:0] MEM_LIM = 32'(MEM_WORDS);

  // config registers
  logic [DBW_W-1:0]  dbw_r;
  logic [LINE_W-1:0] pl_r;
  logic [DLY_W-1:0]  rowd_r, cold_r;

  // architectural state
  logic [31:0]       rvalid_r;
  logic              sp_wr_r;
  logic [ROW_W-1:0]  open_row_r;
  logic [DATA_W-1:0] cycle_r;
  logic [CNT_W-1:0]  stored_r, fresh_r;
  logic [AW-1:0]     clr_addr_r;

  // storage
  logic [DATA_W-1:0] rf_mem [32];
  logic [DATA_W-1:0] rf_qa, rf_qb;
  logic [DATA_W:0]   dmem [MEM_WORDS];
  logic [DATA_W:0]   dm_q;

  // item stage registers
  logic [FUNC_W-1:0]        func_r;
  logic [REG_W-1:0]         rd_r, ra_r, rb_r;
  logic                     ua_r, ub_r;
  logic signed [DATA_W-1:0] imm_r;
  logic [DATA_W-1:0]        va_r, vb_r, prod_r;
  logic signed [33:0]       addr_r;
  logic [AW-1:0]            loc_r;

  // read value with register zero and stack pointer reset folded in
  function automatic logic [DATA_W-1:0] rf_fix(input logic [REG_W-1:0] idx,
                                               input logic [DATA_W-1:0] raw,
                                               input logic sp_wr);
    logic [DATA_W-1:0] v;
    v = raw;
    if (idx == '0) v = '0;
    else if (idx == SP_REG && !sp_wr) v = SP_INIT;
    return v;
  endfunction

  logic [DATA_W-1:0] va_fix, vb_fix, vd;
  logic [REG_W-1:0]  rf_addr_a;

  assign va_fix    = rf_fix(ra_r, rf_qa, sp_wr_r);
  assign vb_fix    = rf_fix(rb_r, rf_qb, sp_wr_r);
  assign vd        = rf_fix(rd_r, rf_qa, sp_wr_r);
  assign rf_addr_a = dp_cmd.read ? rd_r : in_src_a;
  assign dp_sts.clr_last = (clr_addr_r == CLR_LAST);

  // item capture and operand stages
  always_ff @(posedge clk) begin
    if (dp_cmd.accept) begin
      func_r <= in_func;
      rd_r   <= in_dest_reg;
      ra_r   <= in_src_a;
      rb_r   <= in_src_b;
      ua_r   <= in_use_a;
      ub_r   <= in_use_b;
      imm_r  <= in_imm;
    end
    if (dp_cmd.accept || dp_cmd.read) rf_qa <= rf_mem[rf_addr_a];
    if (dp_cmd.accept) rf_qb <= rf_mem[in_src_b];
    if (dp_cmd.read) begin
      va_r   <= va_fix;
      vb_r   <= vb_fix;
      prod_r <= va_fix * vb_fix;
      addr_r <= 34'(imm_r)
              + (ua_r ? 34'($signed(va_fix)) : 34'sd0)
              + (ub_r ? 34'($signed(vb_fix)) : 34'sd0);
    end
    if (dp_cmd.addr) loc_r <= AW'(addr_r[33:2] - {14'd0, dbw_r});
  end

  // data memory read
  always_ff @(posedge clk) begin
    if (dp_cmd.addr) dm_q <= dmem[AW'(addr_r[33:2] - {14'd0, dbw_r})];
  end

  // execute: checks and results
  logic [STS_W-1:0]  sts;
  logic              tk, mem_ok, wen, nw;
  logic [DATA_W-1:0] wval, cyc_nxt, res;
  logic [ROW_W-1:0]  row;
  logic [9:0]        dly;
  logic              va_ok, vb_ok, vd_ok, is_br_tk;
  logic signed [31:0] word;

  assign va_ok = rvalid_r[ra_r];
  assign vb_ok = rvalid_r[rb_r];
  assign vd_ok = rvalid_r[rd_r];
  assign word  = addr_r[33:2];
  assign row   = ROW_W'(addr_r[33:0] >> ROW_SH) + ROW_W'(1);

  always_comb begin
    sts     = STS_OK;
    tk      = 1'b0;
    mem_ok  = 1'b0;
    wen     = 1'b0;
    nw      = 1'b0;
    wval    = '0;
    res     = '0;
    dly     = '0;
    cyc_nxt = cycle_r;
    is_br_tk = 1'b0;
    priority case (1'b1)
      (func_r == FN_ADD || func_r == FN_SUB || func_r == FN_MUL ||
       func_r == FN_SLT): begin
        if (!va_ok || !vb_ok) sts = STS_EMPTY_REG;
        else begin
          priority case (1'b1)
            (func_r == FN_ADD): res = va_r + vb_r;
            (func_r == FN_SUB): res = va_r - vb_r;
            (func_r == FN_MUL): res = prod_r;
            default:            res = {31'd0, $signed(va_r) < $signed(vb_r)};
          endcase
          wen     = 1'b1;
          wval    = res;
          cyc_nxt = cycle_r + 32'd1;
        end
      end
      (func_r == FN_ADDI): begin
        if (!va_ok) sts = STS_EMPTY_REG;
        else begin
          wen     = 1'b1;
          wval    = va_r + imm_r;
          cyc_nxt = cycle_r + 32'd1;
        end
      end
      (func_r == FN_BEQ || func_r == FN_BNE || func_r == FN_J): begin
        if (func_r != FN_J && (!vd_ok || !va_ok)) sts = STS_EMPTY_REG;
        else begin
          is_br_tk = (func_r == FN_J) || ((func_r == FN_BEQ) == (vd == va_r));
          if (!is_br_tk) cyc_nxt = cycle_r + 32'd1;
          else if (imm_r < 32'sd1 || imm_r > $signed({16'd0, pl_r}))
            sts = STS_BAD_TGT;
          else tk = 1'b1;
        end
      end
      (func_r == FN_LW || func_r == FN_SW): begin
        if ((ua_r && !va_ok) || (ub_r && !vb_ok) || (func_r == FN_SW && !vd_ok))
          sts = STS_EMPTY_REG;
        else if (addr_r[1:0] != 2'b00) sts = STS_MISALIGN;
        else if (word < $signed({14'd0, dbw_r}) || word >= MEM_LIM) sts = STS_OOM;
        else if (func_r == FN_LW && !dm_q[DATA_W]) sts = STS_EMPTY_MEM;
        else begin
          mem_ok = 1'b1;
          if (open_row_r == '0) dly = {2'd0, rowd_r} + {2'd0, cold_r};
          else if (open_row_r == row) dly = {2'd0, cold_r};
          else dly = {1'b0, rowd_r, 1'b0} + {2'd0, cold_r};
          cyc_nxt = cycle_r + {22'd0, dly} + 32'd1;
          if (func_r == FN_LW) begin
            wen  = 1'b1;
            wval = dm_q[DATA_W-1:0];
          end else nw = !dm_q[DATA_W];
        end
      end
      default: ;
    endcase
    if (rd_r == '0) wen = 1'b0;
  end

  // config, counters and state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbw_r      <= '0;
      pl_r       <= RST_PROG_LINES;
      rowd_r     <= RST_ROW_DELAY;
      cold_r     <= RST_COL_DELAY;
      rvalid_r   <= RST_REG_VALID;
      sp_wr_r    <= 1'b0;
      open_row_r <= '0;
      cycle_r    <= '0;
      stored_r   <= '0;
      fresh_r    <= '0;
      clr_addr_r <= '0;
    end else begin
      if (dp_cmd.clr && !dp_sts.clr_last) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_DATA_BASE: begin
            dbw_r    <= cfg_data;
            stored_r <= CNT_W'(cfg_data) + fresh_r;
          end
          CFG_PROG_LINES: pl_r   <= cfg_data[LINE_W-1:0];
          CFG_ROW_DELAY:  rowd_r <= cfg_data[DLY_W-1:0];
          CFG_COL_DELAY:  cold_r <= cfg_data[DLY_W-1:0];
          default: ;
        endcase
      end
      if (dp_cmd.exec) begin
        cycle_r <= cyc_nxt;
        if (mem_ok) open_row_r <= row;
        if (wen) begin
          rvalid_r[rd_r] <= 1'b1;
          if (rd_r == SP_REG) sp_wr_r <= 1'b1;
        end
        if (nw) begin
          stored_r <= stored_r + CNT_W'(1);
          fresh_r  <= fresh_r + CNT_W'(1);
        end
      end
    end
  end

  // register file and data memory writes
  always_ff @(posedge clk) begin
    if (dp_cmd.exec && wen) rf_mem[rd_r] <= wval;
    if (dp_cmd.clr) dmem[clr_addr_r] <= '0;
    else if (dp_cmd.exec && mem_ok && func_r == FN_SW) dmem[loc_r] <= {1'b1, vd};
  end

  // result register
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      out_status        <= sts;
      out_taken         <= tk;
      out_next_line     <= tk ? imm_r[LINE_W-1:0] : '0;
      out_dram_issued   <= mem_ok;
      out_issue_cycle   <= mem_ok ? cycle_r + 32'd1 : '0;
      out_cycle_total   <= cyc_nxt;
      out_reg_written   <= wen;
      out_written_index <= wen ? rd_r : '0;
      out_written_value <= wen ? wval : '0;
      out_new_word      <= nw;
      out_words_stored  <= nw ? stored_r + CNT_W'(1) : stored_r;
    end
  end

`ifndef SYNTH
  // register zero never becomes a write target
  a_r0_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.exec && rd_r == '0) |-> !wen)
    else $error("write to register zero");
  // a failing item touches no state
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.exec && sts != STS_OK) |-> (!wen && !mem_ok && !nw && cyc_nxt == cycle_r))
    else $error("failing item changes state");
  // a new word only comes from a store that reached memory
  a_new_word: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.exec && nw) |-> (mem_ok && func_r == FN_SW))
    else $error("new word without store");
`endif

endmodule

[sv/mips_subset_executor_dram_timing_unit.sv]
// ----------------------------------------------------------------------------
// mips_subset_executor_dram_timing_unit
// Executes one decoded MIPS subset instruction per beat with DRAM row timing.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    func, regs, selects, imm
// out      output     out_valid / out_ready  status, branch, dram, reg, counts
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each instruction passes through these stages in order: capture and register
// file read, operand/address/multiply stage, data memory read, execute. the
// result is registered at execute, and the next beat is taken after it. the
// register file and data memory ports set these stages. cfg is always ready.
// after reset the data memory is cleared word by word, with in_ready low.
// a finished result waits in the output register while the next beat is taken;
// execute stalls only while that register is full and out_ready is low.
// ----------------------------------------------------------------------------
module mips_subset_executor_dram_timing_unit #(
  parameter int unsigned MEM_WORDS = msedt_pkg::DEF_MEM_WORDS,
  parameter int unsigned ROW_BYTES = msedt_pkg::DEF_ROW_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [msedt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msedt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [msedt_pkg::FUNC_W-1:0]         in_func,
  input  logic [msedt_pkg::REG_W-1:0]          in_dest_reg,
  input  logic [msedt_pkg::REG_W-1:0]          in_src_a,
  input  logic [msedt_pkg::REG_W-1:0]          in_src_b,
  input  logic                                 in_use_a,
  input  logic                                 in_use_b,
  input  logic signed [msedt_pkg::DATA_W-1:0]  in_imm,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [msedt_pkg::STS_W-1:0]          out_status,
  output logic                                 out_taken,
  output logic [msedt_pkg::LINE_W-1:0]         out_next_line,
  output logic                                 out_dram_issued,
  output logic [msedt_pkg::DATA_W-1:0]         out_issue_cycle,
  output logic [msedt_pkg::DATA_W-1:0]         out_cycle_total,
  output logic                                 out_reg_written,
  output logic [msedt_pkg::REG_W-1:0]          out_written_index,
  output logic signed [msedt_pkg::DATA_W-1:0]  out_written_value,
  output logic                                 out_new_word,
  output logic [msedt_pkg::CNT_W-1:0]          out_words_stored
);
  import msedt_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready = 1'b1;

  // sequencer
  msedt_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_sts    (dp_sts),
    .dp_cmd    (dp_cmd)
  );

  // datapath
  msedt_dp #(
    .MEM_WORDS (MEM_WORDS),
    .ROW_BYTES (ROW_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .dp_cmd            (dp_cmd),
    .dp_sts            (dp_sts),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_dest_reg       (in_dest_reg),
    .in_src_a          (in_src_a),
    .in_src_b          (in_src_b),
    .in_use_a          (in_use_a),
    .in_use_b          (in_use_b),
    .in_imm            (in_imm),
    .out_status        (out_status),
    .out_taken         (out_taken),
    .out_next_line     (out_next_line),
    .out_dram_issued   (out_dram_issued),
    .out_issue_cycle   (out_issue_cycle),
    .out_cycle_total   (out_cycle_total),
    .out_reg_written   (out_reg_written),
    .out_written_index (out_written_index),
    .out_written_value (out_written_value),
    .out_new_word      (out_new_word),
    .out_words_stored  (out_words_stored)
  );

endmodule

[bench/mips_subset_executor_dram_timing_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mips_subset_executor_dram_timing_unit_tb
// Runs directed and random instruction streams through the executor and
// compares every result beat against a behavioral model of the register file,
// word memory, row buffer timing and counters, under several idling patterns.
// ----------------------------------------------------------------------------
module mips_subset_executor_dram_timing_unit_tb;
  import msedt_pkg::*;

  localparam int unsigned MEMW = DEF_MEM_WORDS;
  localparam int unsigned ROWB = DEF_ROW_BYTES;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic              taken;
    logic [LINE_W-1:0] next_line;
    logic              dram_issued;
    logic [31:0]       issue_cycle;
    logic [31:0]       cycle_total;
    logic              reg_written;
    logic [REG_W-1:0]  written_index;
    logic [31:0]       written_value;
    logic              new_word;
    logic [CNT_W-1:0]  words_stored;
  } exec_result_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [FUNC_W-1:0] in_func;
  logic [REG_W-1:0] in_dest_reg;
  logic [REG_W-1:0] in_src_a;
  logic [REG_W-1:0] in_src_b;
  logic in_use_a;
  logic in_use_b;
  logic signed [DATA_W-1:0] in_imm;
  logic out_valid;
  logic out_ready;
  logic [STS_W-1:0] out_status;
  logic out_taken;
  logic [LINE_W-1:0] out_next_line;
  logic out_dram_issued;
  logic [DATA_W-1:0] out_issue_cycle;
  logic [DATA_W-1:0] out_cycle_total;
  logic out_reg_written;
  logic [REG_W-1:0] out_written_index;
  logic signed [DATA_W-1:0] out_written_value;
  logic out_new_word;
  logic [CNT_W-1:0] out_words_stored;

  mips_subset_executor_dram_timing_unit dut (.*);

  // model state
  logic [31:0] gpr_val [32];
  logic        gpr_ok [32];
  logic [31:0] dmem_val [int];
  logic [17:0] base_word;
  logic [15:0] prog_lines;
  logic [7:0]  row_dly;
  logic [7:0]  col_dly;
  logic [31:0] open_row_id;
  logic [31:0] cycle_cnt;
  logic [19:0] stored_cnt;
  logic [19:0] fresh_cnt;

  exec_result_t pending_results[$];
  int  mismatch_count;
  int  results_seen;
  int  items_sent;
  int  send_idle_pct;
  int  recv_stall_pct;
  longint cycle_no;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_no,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what,
               got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'd0, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_status != want.status) report_mismatch("status", out_status, want.status);
        if (out_taken != want.taken) report_mismatch("taken", out_taken, want.taken);
        if (out_next_line != want.next_line)
          report_mismatch("next_line", out_next_line, want.next_line);
        if (out_dram_issued != want.dram_issued)
          report_mismatch("dram_issued", out_dram_issued, want.dram_issued);
        if (out_issue_cycle != want.issue_cycle)
          report_mismatch("issue_cycle", out_issue_cycle, want.issue_cycle);
        if (out_cycle_total != want.cycle_total)
          report_mismatch("cycle_total", out_cycle_total, want.cycle_total);
        if (out_reg_written != want.reg_written)
          report_mismatch("reg_written", out_reg_written, want.reg_written);
        if (out_written_index != want.written_index)
          report_mismatch("written_index", out_written_index, want.written_index);
        if (out_written_value != want.written_value)
          report_mismatch("written_value", out_written_value, want.written_value);
        if (out_new_word != want.new_word)
          report_mismatch("new_word", out_new_word, want.new_word);
        if (out_words_stored != want.words_stored)
          report_mismatch("words_stored", out_words_stored, want.words_stored);
      end
      results_seen++;
    end
  end

  function automatic void model_reset();
    for (int r = 0; r < 32; r++) begin
      gpr_val[r] = 32'd0;
      gpr_ok[r] = RST_REG_VALID[r];
    end
    gpr_val[SP_REG] = SP_INIT;
    dmem_val.delete();
    base_word = '0;
    prog_lines = RST_PROG_LINES;
    row_dly = RST_ROW_DELAY;
    col_dly = RST_COL_DELAY;
    open_row_id = 32'd0;
    cycle_cnt = 32'd0;
    stored_cnt = '0;
    fresh_cnt = '0;
  endfunction

  function automatic void gpr_write(input logic [4:0] idx, input logic [31:0] v,
                                    inout exec_result_t res);
    if (idx != 5'd0) begin
      gpr_val[idx] = v;
      gpr_ok[idx] = 1'b1;
      res.reg_written = 1'b1;
      res.written_index = idx;
      res.written_value = v;
    end
  endfunction

  // behavioral prediction of one instruction
  function automatic exec_result_t execute_instr(
      input logic [3:0] fn, input logic [4:0] rd, input logic [4:0] ra,
      input logic [4:0] rb, input logic ua, input logic ub,
      input logic signed [31:0] imm);
    exec_result_t res;
    logic [31:0] va, vb, vd, r;
    longint addr, loc;
    logic [31:0] row;
    logic tk;
    res = '0;
    va = gpr_val[ra];
    vb = gpr_val[rb];
    vd = gpr_val[rd];
    case (fn)
      FN_ADD, FN_SUB, FN_MUL, FN_SLT: begin
        if (!gpr_ok[ra] || !gpr_ok[rb]) begin
          res.status = STS_EMPTY_REG;
        end else begin
          if (fn == FN_ADD) r = va + vb;
          else if (fn == FN_SUB) r = va - vb;
          else if (fn == FN_MUL) r = va * vb;
          else r = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
          gpr_write(rd, r, res);
          cycle_cnt += 1;
        end
      end
      FN_ADDI: begin
        if (!gpr_ok[ra]) res.status = STS_EMPTY_REG;
        else begin
          gpr_write(rd, va + imm, res);
          cycle_cnt += 1;
        end
      end
      FN_BEQ, FN_BNE, FN_J: begin
        if (fn != FN_J && (!gpr_ok[rd] || !gpr_ok[ra])) begin
          res.status = STS_EMPTY_REG;
        end else begin
          tk = (fn == FN_J) || ((fn == FN_BEQ) == (vd == va));
          if (!tk) cycle_cnt += 1;
          else if (imm < 1 || longint'(imm) > longint'(prog_lines))
            res.status = STS_BAD_TGT;
          else begin
            res.taken = 1'b1;
            res.next_line = imm[15:0];
          end
        end
      end
      FN_LW, FN_SW: begin
        addr = imm;
        loc = 0;
        if ((ua && !gpr_ok[ra]) || (ub && !gpr_ok[rb]) || (fn == FN_SW && !gpr_ok[rd]))
          res.status = STS_EMPTY_REG;
        else begin
          if (ua) addr += longint'($signed(va));
          if (ub) addr += longint'($signed(vb));
          if (addr[1:0] != 2'b00) res.status = STS_MISALIGN;
          else begin
            loc = addr / 4 - longint'(base_word);
            if (loc < 0 || loc >= longint'(MEMW) - longint'(base_word))
              res.status = STS_OOM;
            else if (fn == FN_LW && !dmem_val.exists(int'(loc)))
              res.status = STS_EMPTY_MEM;
          end
        end
        if (res.status == STS_OK) begin
          row = 32'(addr / ROWB) + 32'd1;
          res.dram_issued = 1'b1;
          res.issue_cycle = cycle_cnt + 32'd1;
          if (open_row_id == 32'd0) cycle_cnt += row_dly + col_dly;
          else if (open_row_id == row) cycle_cnt += col_dly;
          else cycle_cnt += 2 * row_dly + col_dly;
          open_row_id = row;
          if (fn == FN_LW) gpr_write(rd, dmem_val[int'(loc)], res);
          else begin
            if (!dmem_val.exists(int'(loc))) begin
              res.new_word = 1'b1;
              fresh_cnt += 1;
              stored_cnt += 1;
            end
            dmem_val[int'(loc)] = vd;
          end
          cycle_cnt += 1;
        end
      end
      default: ;
    endcase
    res.cycle_total = cycle_cnt;
    res.words_stored = stored_cnt;
    return res;
  endfunction

  // one instruction beat; valid stays high into the next beat unless idling
  task automatic send_instr(input logic [3:0] fn, input logic [4:0] rd,
                            input logic [4:0] ra, input logic [4:0] rb,
                            input logic ua, input logic ub,
                            input logic signed [31:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_dest_reg <= rd;
    in_src_a <= ra;
    in_src_b <= rb;
    in_use_a <= ua;
    in_use_b <= ub;
    in_imm <= imm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.insert(pending_results.size(),
                           execute_instr(fn, rd, ra, rb, ua, ub, imm));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [17:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DATA_BASE: begin
        base_word = v;
        stored_cnt = 20'(base_word) + fresh_cnt;
      end
      CFG_PROG_LINES: prog_lines = v[15:0];
      CFG_ROW_DELAY: row_dly = v[7:0];
      default: col_dly = v[7:0];
    endcase
  endtask

  // a memory address near the data area, always aligned and in range
  function automatic logic signed [31:0] data_addr();
    int unsigned w;
    w = 32'(base_word) + $urandom_range(63);
    if ($urandom_range(3) == 0) w = 32'(base_word) + $urandom_range(4095);
    if (w >= MEMW) w = MEMW - 1;
    return signed'(w * 4);
  endfunction

  task automatic test_directed();
    send_instr(FN_ADD, 5'd1, 5'd0, 5'd29, 1'b1, 1'b1, 32'sd0);
    send_instr(FN_ADD, 5'd2, 5'd3, 5'd0, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_ADDI, 5'd3, 5'd0, 5'd0, 1'b0, 1'b0, 32'sh7fffffff);
    send_instr(FN_ADDI, 5'd4, 5'd0, 5'd0, 1'b0, 1'b0, 32'sh80000000);
    send_instr(FN_ADD, 5'd5, 5'd3, 5'd3, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_SUB, 5'd6, 5'd4, 5'd3, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_MUL, 5'd7, 5'd3, 5'd4, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_SLT, 5'd8, 5'd4, 5'd3, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_SLT, 5'd0, 5'd3, 5'd4, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_BEQ, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 32'sd1);
    send_instr(FN_BNE, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 32'sd1);
    send_instr(FN_BEQ, 5'd0, 5'd0, 5'd0, 1'b1, 1'b1, 32'sd2);
    send_instr(FN_J, 5'd31, 5'd31, 5'd31, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_J, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 32'sh80000000);
    send_instr(FN_SW, 5'd3, 5'd0, 5'd0, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_SW, 5'd4, 5'd0, 5'd0, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_LW, 5'd9, 5'd0, 5'd0, 1'b0, 1'b0, 32'sd0);
    send_instr(FN_LW, 5'd10, 5'd0, 5'd0, 1'b0, 1'b0, 32'sd4);
    send_instr(FN_SW, 5'd3, 5'd29, 5'd0, 1'b1, 1'b0, 32'sd2);
    send_instr(FN_SW, 5'd3, 5'd0, 5'd0, 1'b0, 1'b0, 32'sh7ffffffc);
    send_instr(FN_LW, 5'd11, 5'd3, 5'd3, 1'b1, 1'b1, 32'sd2);
    send_instr(FN_SW, 5'd3, 5'd0, 5'd0, 1'b0, 1'b0, 32'(MEMW * 4 - 4));
    send_instr(FN_LW, 5'd12, 5'd20, 5'd0, 1'b1, 1'b0, 32'sd0);
    send_instr(4'd15, 5'd31, 5'd31, 5'd31, 1'b1, 1'b1, 32'sh7fffffff);
    send_instr(4'd10, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 32'sd0);
  endtask

  // random instructions, with store then load pairs on a live data area
  task automatic test_random(input int count);
    logic [3:0] fn;
    logic signed [31:0] imm, a;
    logic [4:0] rd, ra, rb;
    for (int k = 0; k < count; k++) begin
      rd = 5'($urandom_range(31));
      ra = 5'($urandom_range(31));
      rb = 5'($urandom_range(31));
      case ($urandom_range(9))
        0, 1: begin
          a = data_addr();
          send_instr(FN_SW, rd, 5'd0, 5'd0, 1'b0, 1'b0, a);
          send_instr(FN_LW, 5'($urandom_range(31)), 5'd0, 5'd0, 1'b0, 1'b0, a);
        end
        2: begin
          // based address through a register seeded with addi
          a = data_addr();
          send_instr(FN_ADDI, 5'd20, 5'd0, 5'd0, 1'b0, 1'b0, a - 32'sd16);
          send_instr($urandom_range(1) ? FN_LW : FN_SW, rd, 5'd20, 5'd0, 1'b1,
                     1'($urandom_range(1)), 32'sd16);
        end
        3: begin
          fn = $urandom_range(2) == 0 ? FN_J : ($urandom_range(1) ? FN_BEQ : FN_BNE);
          imm = $urandom_range(3) == 0 ? $signed($urandom()) :
                32'($urandom_range(32'(prog_lines) + 1));
          send_instr(fn, rd, ra, rb, 1'($urandom_range(1)), 1'($urandom_range(1)), imm);
        end
        4: begin
          imm = $urandom_range(1) ? $signed($urandom()) : data_addr();
          send_instr($urandom_range(1) ? FN_LW : FN_SW, rd, ra, rb,
                     1'($urandom_range(1)), 1'($urandom_range(1)), imm);
        end
        5: send_instr(FN_ADDI, rd, ra, rb, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      $signed($urandom()));
        9: send_instr(4'($urandom_range(15)), rd, ra, rb, 1'($urandom_range(1)),
                      1'($urandom_range(1)), $signed($urandom()));
        default: begin
          fn = $urandom_range(3) == 3 ? FN_SLT : 4'($urandom_range(2));
          send_instr(fn, rd, ra, rb, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     $signed($urandom()));
        end
      endcase
    end
  endtask

  task automatic test_config_phase(input logic [17:0] base, input logic [15:0] lines,
                                   input logic [7:0] rdly, input logic [7:0] cdly);
    wait_drained();
    write_cfg(CFG_DATA_BASE, base);
    write_cfg(CFG_PROG_LINES, 18'(lines));
    write_cfg(CFG_ROW_DELAY, 18'(rdly));
    write_cfg(CFG_COL_DELAY, 18'(cdly));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cycle_no = 0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_func = '0;
    in_dest_reg = '0;
    in_src_a = '0;
    in_src_b = '0;
    in_use_a = 1'b0;
    in_use_b = 1'b0;
    in_imm = '0;
    mismatch_count = 0;
    results_seen = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_phase(18'd0, 16'd65535, 8'd0, 8'd0);
    test_random(130);
    test_config_phase(18'd100, 16'd1, 8'd255, 8'd255);
    send_idle_pct = 81;
    test_random(130);
    test_config_phase(18'd262143, 16'd20, 8'd3, 8'd1);
    recv_stall_pct = 81;
    send_idle_pct = 0;
    test_random(70);
    test_config_phase(18'd4096, 16'd300, 8'd17, 8'd5);
    send_idle_pct = 8;
    recv_stall_pct = 8;
    test_random(130);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(70);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d instructions, checked %0d results under five register settings",
             items_sent, results_seen);
    $display("idling phases: none, sender, receiver, both; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
